/* design/pli_pkg.sv */
`default_nettype none
package pli_pkg;
    localparam int MaxPointsDefault = 64;
    localparam int FifoDepth = 2;

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_QUERY  = 2'd1,
        K_CLEAR  = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_INSIDE = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2,
        ST_FEW    = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] x;
        logic [31:0] y;
    } t_cmd;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* design/piecewise_linear_interpolator_core.sv */
// Piecewise linear interpolator core.
// Command channel: an item is a transfer at a clock edge with start high and
// busy low. Kind 0 appends breakpoint (x,y), kind 1 queries x, kind 2 clears.
// Items enter a two-entry queue; busy rises only when the queue is full.
// The back end runs one item at a time from the queue.
// Append: a bit-serial 49-step slope division
// followed by one multiply for the offset.
// Query: a binary search over
// the breakpoint memories (one registered read per probe) and one multiply.
// Clear and fewer-than-two-point queries are handled without leaving the idle state.
// Results: o_strobe is high for one cycle with o_y_out, o_slope_out and
// o_status; the receiver cannot stall and takes every strobe.
// Reset (i_rst_n low, synchronous) empties the queue and the table;
// the breakpoint memories are not cleared.
`default_nettype none
module piecewise_linear_interpolator_core
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_x_value,
    input  wire logic [31:0] i_y_value,
    output logic             o_strobe,
    output logic [31:0]      o_y_out,
    output logic [31:0]      o_slope_out,
    output logic [1:0]       o_status
);
    logic fvalid, pop;
    t_cmd cmd;

    pli_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_kind, .i_x_value, .i_y_value,
        .o_busy(busy), .o_valid(fvalid), .o_cmd(cmd), .i_pop(pop)
    );

    pli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk, .i_rst_n, .i_valid(fvalid), .i_cmd(cmd), .o_pop(pop),
        .o_strobe, .o_y_out, .o_slope_out, .o_status
    );

`ifndef ASSERT_OFF
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> fvalid) else $error("pop from empty queue");
    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FEW) |-> (o_y_out == '0 && o_slope_out == '0))
        else $error("short table result not zero");
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> fvalid) else $error("busy with empty queue");
`endif
endmodule
`default_nettype wire

/* design/pli_front.sv */
`default_nettype none
module pli_front
    import pli_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_x_value,
    input  wire logic [31:0] i_y_value,
    output logic             o_busy,
    output logic             o_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_pop
);
    t_cmd      r_q [FifoDepth];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       push;
    t_cmd       c;

    assign o_busy  = (r_cnt == 2'(FifoDepth));
    assign push    = i_start && !o_busy && (i_kind != K_NONE);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        c.kind = t_kind'(i_kind);
        c.x    = i_x_value;
        c.y    = i_y_value;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= c;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

/* design/pli_back.sv */
`default_nettype none
module pli_back
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [31:0]      o_y_out,
    output logic [31:0]      o_slope_out,
    output logic [1:0]       o_status
);
    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_AXRD  = 11'b00000000010,
        S_ACHK  = 11'b00000000100,
        S_DIV   = 11'b00000001000,
        S_AMUL  = 11'b00000010000,
        S_AWR   = 11'b00000100000,
        S_QRD   = 11'b00001000000,
        S_QSRCH = 11'b00010000000,
        S_QSEG  = 11'b00100000000,
        S_QMUL  = 11'b01000000000,
        S_QOUT  = 11'b10000000000
    } t_state;

    t_state r_st;
    logic [31:0] r_lx [MAX_POINTS];
    logic [31:0] r_sl [MAX_POINTS];
    logic [31:0] r_of [MAX_POINTS];
    logic [CW-1:0] r_n;
    logic [31:0] r_last_y, r_x, r_y, r_px, r_lxd, r_sld, r_ofd, r_first, r_lastx;
    logic [AW-1:0] r_ra;
    logic [CW-1:0] r_lo, r_hi;
    logic [48:0] r_rem, r_quo, r_num;
    logic [32:0] r_den;
    logic        r_neg;
    logic [5:0]  r_bit;
    logic signed [65:0] r_prod;
    logic [31:0] r_slope;
    logic        r_strobe;
    logic [31:0] r_yo, r_so;
    logic [1:0]  r_sto;
    logic [1:0]  r_qst;
    logic        r_phase;

    logic signed [32:0] dy, dx;
    logic [49:0] trem;
    logic [CW-1:0] mid;
    logic signed [65:0] mq;

    assign o_strobe    = r_strobe;
    assign o_y_out     = r_yo;
    assign o_slope_out = r_so;
    assign o_status    = r_sto;
    assign o_pop       = (r_st == S_IDLE) && i_valid;

    assign dy   = $signed({r_y[31], r_y}) - $signed({r_last_y[31], r_last_y});
    assign dx   = $signed({r_x[31], r_x}) - $signed({r_px[31], r_px});
    assign trem = {r_rem, r_num[48]};
    assign mid  = CW'((r_lo + r_hi + 1'b1) >> 1);
    assign mq   = 66'(r_prod >>> 16);

    always_ff @(posedge i_clk) begin
        r_lxd <= r_lx[r_ra];
        r_sld <= r_sl[r_ra];
        r_ofd <= r_of[r_ra];
        if (r_st == S_AWR) begin
            r_lx[AW'(r_n)] <= r_x;
            if (r_n != '0) begin
                r_sl[AW'(r_n - 1'b1)] <= r_slope;
                r_of[AW'(r_n - 1'b1)] <= sat32($signed({{34{r_last_y[31]}}, r_last_y}) - mq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_n      <= '0;
            r_last_y <= '0;
            r_strobe <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x <= i_cmd.x;
                        r_y <= i_cmd.y;
                        case (i_cmd.kind)
                            K_APPEND: begin
                                r_ra <= AW'(r_n - 1'b1);
                                if (r_n == CW'(MAX_POINTS)) begin
                                    r_st <= S_IDLE;
                                end else if (r_n == '0) begin
                                    r_st <= S_AWR;
                                end else begin
                                    r_st <= S_AXRD;
                                end
                            end
                            K_QUERY: begin
                                if (r_n < CW'(2)) begin
                                    r_yo     <= '0;
                                    r_so     <= '0;
                                    r_sto    <= ST_FEW;
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_ra    <= '0;
                                    r_phase <= 1'b0;
                                    r_st    <= S_QRD;
                                end
                            end
                            K_CLEAR: begin
                                r_n      <= '0;
                                r_last_y <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_AXRD: r_st <= S_ACHK;
                S_ACHK: begin
                    r_px <= r_lxd;
                    if ($signed(r_x) <= $signed(r_lxd)) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_DIV;
                        r_bit <= 6'd49;
                    end
                end
                S_DIV: begin
                    if (r_bit == 6'd49) begin
                        r_neg <= dy[32];
                        r_num <= {(dy[32] ? 33'(-dy) : 33'(dy)), 16'd0};
                        r_den <= 33'(dx);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_bit <= 6'd48;
                    end else begin
                        r_num <= r_num << 1;
                        if (trem >= {17'd0, r_den}) begin
                            r_rem <= 49'(trem - {17'd0, r_den});
                            r_quo <= {r_quo[47:0], 1'b1};
                        end else begin
                            r_rem <= trem[48:0];
                            r_quo <= {r_quo[47:0], 1'b0};
                        end
                        if (r_bit == 6'd0) begin
                            r_st <= S_AMUL;
                        end else begin
                            r_bit <= r_bit - 1'b1;
                        end
                    end
                end
                S_AMUL: begin
                    if (!r_phase) begin
                        r_slope <= sat32(r_neg ? -$signed({17'd0, r_quo})
                                               : $signed({17'd0, r_quo}));
                        r_phase <= 1'b1;
                    end else begin
                        r_prod  <= 66'($signed(r_slope) * $signed(r_px));
                        r_phase <= 1'b0;
                        r_st    <= S_AWR;
                    end
                end
                S_AWR: begin
                    r_n      <= r_n + 1'b1;
                    r_last_y <= r_y;
                    r_st     <= S_IDLE;
                end
                S_QRD: begin
                    if (!r_phase) begin
                        r_ra    <= AW'(r_n - 1'b1);
                        r_phase <= 1'b1;
                    end else begin
                        r_first <= r_lxd;
                        r_phase <= 1'b0;
                        r_lo    <= '0;
                        r_hi    <= r_n - CW'(2);
                        r_st    <= S_QSRCH;
                    end
                end
                S_QSRCH: begin
                    if (!r_phase) begin
                        if (r_lo == '0 && r_hi == r_n - CW'(2)) begin
                            r_lastx <= r_lxd;
                        end
                        if (r_lo == r_hi) begin
                            r_ra    <= AW'(r_lo);
                            r_st    <= S_QSEG;
                        end else begin
                            r_ra    <= AW'(mid);
                            r_phase <= 1'b1;
                        end
                    end else if (r_ra == AW'(mid) && r_bit == 6'd63) begin
                        r_bit <= 6'd0;
                        r_phase <= 1'b0;
                        if ($signed(r_lxd) < $signed(r_x)) begin
                            r_lo <= mid;
                        end else begin
                            r_hi <= mid - 1'b1;
                        end
                    end else begin
                        r_bit <= 6'd63;
                    end
                end
                S_QSEG: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_prod  <= 66'($signed(r_sld) * $signed(r_x));
                        r_slope <= r_sld;
                        r_phase <= 1'b0;
                        if ($signed(r_x) <= $signed(r_first)) begin
                            r_qst <= ST_BELOW;
                        end else if ($signed(r_x) > $signed(r_lastx)) begin
                            r_qst <= ST_ABOVE;
                        end else begin
                            r_qst <= ST_INSIDE;
                        end
                        r_st <= S_QMUL;
                    end
                end
                S_QMUL: begin
                    r_prod <= $signed({{34{r_ofd[31]}}, r_ofd}) + mq;
                    r_st   <= S_QOUT;
                end
                S_QOUT: begin
                    r_yo     <= sat32(r_prod);
                    r_so     <= r_slope;
                    r_sto    <= r_qst;
                    r_strobe <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
